[hdl/cau_pkg.sv]
// Shared definitions for the complex arithmetic unit: opcodes, status codes,
// the per-stage beat record and the saturation helpers. No dependencies.
`default_nettype none

package cau_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int NSTEP         = 32;   // quotient bits and root bits
    localparam int CORDIC_STEPS  = 30;
    localparam int REM_W         = 96;

    localparam logic [3:0] FN_ADD   = 4'd0;
    localparam logic [3:0] FN_SUB   = 4'd1;
    localparam logic [3:0] FN_NEG   = 4'd2;
    localparam logic [3:0] FN_CONJ  = 4'd3;
    localparam logic [3:0] FN_MUL   = 4'd4;
    localparam logic [3:0] FN_DIV   = 4'd5;
    localparam logic [3:0] FN_EQ    = 4'd6;
    localparam logic [3:0] FN_MOD   = 4'd7;
    localparam logic [3:0] FN_ANGLE = 4'd8;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_ZMOD = 2'd2;
    localparam logic [1:0] ST_SAT  = 2'd3;

    localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] INT_MIN = 32'h8000_0000;

    localparam logic [33:0] HALF_PI_Q30 = 34'h0_6487_ED51;

    localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
    };

    // One beat as it travels through the iteration stages
    typedef struct packed {
        logic [3:0]       func;
        logic [31:0]      res_re;
        logic [31:0]      res_im;
        logic             is_eq;
        logic [1:0]       status;
        logic             divz;
        logic             zmod;
        logic             ovf_re;
        logic             ovf_im;
        logic             neg_re;
        logic             neg_im;
        logic [63:0]      den;
        logic [REM_W-1:0] rem_re;
        logic [REM_W-1:0] rem_im;
        logic [31:0]      q_re;
        logic [31:0]      q_im;
        logic [63:0]      sq_n;
        logic [63:0]      sq_res;
        logic [33:0]      cx;
        logic [33:0]      cy;
        logic [33:0]      cz;
    } step_t;

    // Sign and magnitude to signed 32 bits; bit 32 flags saturation
    function automatic logic [32:0] sat_mag(input logic neg, input logic [64:0] mag);
        logic [32:0] r;
        if (neg) begin
            if (mag > 65'h0_8000_0000)
                r = {1'b1, INT_MIN};
            else
                r = {1'b0, 32'(32'd0 - mag[31:0])};
        end
        else begin
            if (mag > 65'h0_7FFF_FFFF)
                r = {1'b1, INT_MAX};
            else
                r = {1'b0, mag[31:0]};
        end
        return r;
    endfunction

    // Clamp a 33-bit signed value to 32 bits; bit 32 flags saturation
    function automatic logic [32:0] sat33(input logic signed [32:0] v);
        logic [32:0] r;
        if (v > 33'sd2147483647)
            r = {1'b1, INT_MAX};
        else if (v < -33'sd2147483648)
            r = {1'b1, INT_MIN};
        else
            r = {1'b0, v[31:0]};
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/cau_front.sv]
// Front stages of the complex arithmetic unit: operand capture, products,
// sums, magnitudes and iteration setup. Depends on cau_pkg.
`default_nettype none

module cau_front #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               adv,
    input  wire logic               in_valid,
    input  wire logic [3:0]         func,
    input  wire logic signed [31:0] a_re,
    input  wire logic signed [31:0] a_im,
    input  wire logic signed [31:0] b_re,
    input  wire logic signed [31:0] b_im,
    input  wire logic [31:0]        tol,
    output logic                    out_valid,
    output cau_pkg::step_t          out_data
);
    import cau_pkg::*;

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        return v[31] ? 32'(32'd0 - v) : v;
    endfunction

    function automatic logic [31:0] abs33(input logic signed [32:0] v);
        return v[32] ? 32'(33'd0 - v) : v[31:0];
    endfunction

    // Stage 0 registers
    logic               r0_valid_reg;
    logic [3:0]         r0_func_reg;
    logic signed [31:0] r0_ar_reg, r0_ai_reg, r0_br_reg, r0_bi_reg;
    logic [31:0]        r0_ma_reg, r0_mb_reg;
    logic [31:0]        r0_ma_next, r0_mb_next;
    logic signed [32:0] d1_w, d2_w;

    // Stage 1 registers
    logic               r1_valid_reg;
    logic [3:0]         r1_func_reg;
    logic signed [63:0] r1_prb_reg, r1_pib_reg, r1_prib_reg, r1_pirb_reg;
    logic [63:0]        r1_sqa_reg, r1_sqb_reg;
    logic [31:0]        r1_res_re_reg, r1_res_im_reg, r1_res_re_next, r1_res_im_next;
    logic [1:0]         r1_status_reg, r1_status_next;
    logic               r1_divz_reg, r1_zmod_reg, r1_swap_reg;
    logic [31:0]        r1_ax_reg, r1_ay_reg, r1_ax_next, r1_ay_next;
    logic [32:0]        s_re_w, s_im_w;

    // Stage 2 registers
    logic               r2_valid_reg;
    logic [3:0]         r2_func_reg;
    logic signed [65:0] r2_tre_reg, r2_tim_reg, r2_tre_next, r2_tim_next;
    logic [64:0]        r2_ssum_reg;
    logic [31:0]        r2_res_re_reg, r2_res_im_reg;
    logic [1:0]         r2_status_reg;
    logic               r2_divz_reg, r2_zmod_reg, r2_swap_reg;
    logic [31:0]        r2_ax_reg, r2_ay_reg;
    logic [4:0]         r2_sh_reg, r2_sh_next;
    logic [4:0]         msb_w;
    logic [31:0]        or_w;

    // Stage 3 registers
    logic               r3_valid_reg;
    logic [3:0]         r3_func_reg;
    logic               r3_neg_re_reg, r3_neg_im_reg;
    logic [64:0]        r3_mag_re_reg, r3_mag_im_reg;
    logic [63:0]        r3_den_reg;
    logic               r3_eq_reg;
    logic [31:0]        r3_res_re_reg, r3_res_im_reg;
    logic [1:0]         r3_status_reg;
    logic               r3_divz_reg, r3_zmod_reg, r3_swap_reg;
    logic [31:0]        r3_cx_reg, r3_cy_reg;

    // Stage 4 (handed to the iteration stages)
    logic               r4_valid_reg;
    step_t              r4_data_reg, r4_data_next;
    logic [32:0]        mul_re_w, mul_im_w;
    logic [REM_W-1:0]   n_re_w, n_im_w, dlim_w;

    // Pick the operands that feed the squaring multipliers
    always_comb
    begin
        d1_w = 33'(a_re) - 33'(b_re);
        d2_w = 33'(a_im) - 33'(b_im);
        case (func)
            FN_MOD:
            begin
                r0_ma_next = abs32(a_re);
                r0_mb_next = abs32(a_im);
            end
            FN_DIV:
            begin
                r0_ma_next = abs32(b_re);
                r0_mb_next = abs32(b_im);
            end
            default:
            begin
                r0_ma_next = abs33(d1_w);
                r0_mb_next = abs33(d2_w);
            end
        endcase
    end

    // Short ops and angle setup
    always_comb
    begin
        s_re_w         = '0;
        s_im_w         = '0;
        r1_res_re_next = '0;
        r1_res_im_next = '0;
        case (r0_func_reg)
            FN_ADD:
            begin
                s_re_w = sat33(33'(r0_ar_reg) + 33'(r0_br_reg));
                s_im_w = sat33(33'(r0_ai_reg) + 33'(r0_bi_reg));
            end
            FN_SUB:
            begin
                s_re_w = sat33(33'(r0_ar_reg) - 33'(r0_br_reg));
                s_im_w = sat33(33'(r0_ai_reg) - 33'(r0_bi_reg));
            end
            FN_NEG:
            begin
                s_re_w = sat33(33'sd0 - 33'(r0_ar_reg));
                s_im_w = sat33(33'sd0 - 33'(r0_ai_reg));
            end
            FN_CONJ:
            begin
                s_re_w = {1'b0, r0_ar_reg};
                s_im_w = sat33(33'sd0 - 33'(r0_ai_reg));
            end
            default:
            begin
                s_re_w = '0;
                s_im_w = '0;
            end
        endcase
        r1_res_re_next = s_re_w[31:0];
        r1_res_im_next = s_im_w[31:0];
        r1_status_next = (s_re_w[32] || s_im_w[32]) ? ST_SAT : ST_OK;
        // Fold the operand into the first quadrant, swapping the parts in the left half plane
        if (r0_ar_reg[31])
        begin
            r1_ax_next = abs32(r0_ai_reg);
            r1_ay_next = abs32(r0_ar_reg);
        end
        else
        begin
            r1_ax_next = r0_ar_reg;
            r1_ay_next = abs32(r0_ai_reg);
        end
    end

    // Cross sums and normalize shift count
    always_comb
    begin
        if (r1_func_reg == FN_DIV)
        begin
            r2_tre_next = 66'(r1_prb_reg) + 66'(r1_pib_reg);
            r2_tim_next = 66'(r1_pirb_reg) - 66'(r1_prib_reg);
        end
        else
        begin
            r2_tre_next = 66'(r1_prb_reg) - 66'(r1_pib_reg);
            r2_tim_next = 66'(r1_prib_reg) + 66'(r1_pirb_reg);
        end
        or_w  = r1_ax_reg | r1_ay_reg;
        msb_w = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (or_w[i])
                msb_w = 5'(i);
        end
        r2_sh_next = (msb_w >= 5'd30) ? 5'd0 : 5'(5'd30 - msb_w);
    end

    // Truncate products, set up division and CORDIC
    always_comb
    begin
        mul_re_w = sat_mag(r3_neg_re_reg, r3_mag_re_reg >> FRAC_BITS);
        mul_im_w = sat_mag(r3_neg_im_reg, r3_mag_im_reg >> FRAC_BITS);
        n_re_w   = REM_W'(r3_mag_re_reg) << FRAC_BITS;
        n_im_w   = REM_W'(r3_mag_im_reg) << FRAC_BITS;
        dlim_w   = REM_W'(r3_den_reg) << NSTEP;

        r4_data_next.func   = r3_func_reg;
        if (r3_func_reg == FN_MUL)
        begin
            r4_data_next.res_re = mul_re_w[31:0];
            r4_data_next.res_im = mul_im_w[31:0];
            r4_data_next.status = (mul_re_w[32] || mul_im_w[32]) ? ST_SAT : ST_OK;
        end
        else
        begin
            r4_data_next.res_re = r3_res_re_reg;
            r4_data_next.res_im = r3_res_im_reg;
            r4_data_next.status = r3_status_reg;
        end
        r4_data_next.is_eq  = r3_eq_reg;
        r4_data_next.divz   = r3_divz_reg;
        r4_data_next.zmod   = r3_zmod_reg;
        r4_data_next.ovf_re = n_re_w >= dlim_w;
        r4_data_next.ovf_im = n_im_w >= dlim_w;
        r4_data_next.neg_re = r3_neg_re_reg;
        r4_data_next.neg_im = r3_neg_im_reg;
        r4_data_next.den    = r3_den_reg;
        r4_data_next.rem_re = n_re_w;
        r4_data_next.rem_im = n_im_w;
        r4_data_next.q_re   = '0;
        r4_data_next.q_im   = '0;
        r4_data_next.sq_n   = r3_den_reg;
        r4_data_next.sq_res = '0;
        r4_data_next.cx     = {2'b00, r3_cx_reg};
        r4_data_next.cy     = {2'b00, r3_cy_reg};
        r4_data_next.cz     = r3_swap_reg ? HALF_PI_Q30 : '0;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r0_valid_reg <= 1'b0;
            r1_valid_reg <= 1'b0;
            r2_valid_reg <= 1'b0;
            r3_valid_reg <= 1'b0;
            r4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            r0_valid_reg <= in_valid;
            r1_valid_reg <= r0_valid_reg;
            r2_valid_reg <= r1_valid_reg;
            r3_valid_reg <= r2_valid_reg;
            r4_valid_reg <= r3_valid_reg;
        end
    end

    // Payload, advance with the pipe
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r0_func_reg   <= func;
            r0_ar_reg     <= a_re;
            r0_ai_reg     <= a_im;
            r0_br_reg     <= b_re;
            r0_bi_reg     <= b_im;
            r0_ma_reg     <= r0_ma_next;
            r0_mb_reg     <= r0_mb_next;

            r1_func_reg   <= r0_func_reg;
            r1_prb_reg    <= r0_ar_reg * r0_br_reg;
            r1_pib_reg    <= r0_ai_reg * r0_bi_reg;
            r1_prib_reg   <= r0_ar_reg * r0_bi_reg;
            r1_pirb_reg   <= r0_ai_reg * r0_br_reg;
            r1_sqa_reg    <= r0_ma_reg * r0_ma_reg;
            r1_sqb_reg    <= r0_mb_reg * r0_mb_reg;
            r1_res_re_reg <= r1_res_re_next;
            r1_res_im_reg <= r1_res_im_next;
            r1_status_reg <= r1_status_next;
            r1_divz_reg   <= (r0_br_reg == 32'sd0) && (r0_bi_reg == 32'sd0);
            r1_zmod_reg   <= (r0_ar_reg == 32'sd0) && (r0_ai_reg == 32'sd0);
            r1_swap_reg   <= r0_ar_reg[31];
            r1_ax_reg     <= r1_ax_next;
            r1_ay_reg     <= r1_ay_next;

            r2_func_reg   <= r1_func_reg;
            r2_tre_reg    <= r2_tre_next;
            r2_tim_reg    <= r2_tim_next;
            r2_ssum_reg   <= 65'(r1_sqa_reg) + 65'(r1_sqb_reg);
            r2_res_re_reg <= r1_res_re_reg;
            r2_res_im_reg <= r1_res_im_reg;
            r2_status_reg <= r1_status_reg;
            r2_divz_reg   <= r1_divz_reg;
            r2_zmod_reg   <= r1_zmod_reg;
            r2_swap_reg   <= r1_swap_reg;
            r2_ax_reg     <= r1_ax_reg;
            r2_ay_reg     <= r1_ay_reg;
            r2_sh_reg     <= r2_sh_next;

            r3_func_reg   <= r2_func_reg;
            r3_neg_re_reg <= r2_tre_reg[65];
            r3_neg_im_reg <= r2_tim_reg[65];
            r3_mag_re_reg <= r2_tre_reg[65] ? 65'(66'sd0 - r2_tre_reg) : r2_tre_reg[64:0];
            r3_mag_im_reg <= r2_tim_reg[65] ? 65'(66'sd0 - r2_tim_reg) : r2_tim_reg[64:0];
            r3_den_reg    <= r2_ssum_reg[63:0];
            r3_eq_reg     <= (r2_func_reg == FN_EQ)
                             && (r2_ssum_reg <= (65'(tol) << FRAC_BITS));
            r3_res_re_reg <= r2_res_re_reg;
            r3_res_im_reg <= r2_res_im_reg;
            r3_status_reg <= r2_status_reg;
            r3_divz_reg   <= r2_divz_reg;
            r3_zmod_reg   <= r2_zmod_reg;
            r3_swap_reg   <= r2_swap_reg;
            r3_cx_reg     <= r2_ax_reg << r2_sh_reg;
            r3_cy_reg     <= r2_ay_reg << r2_sh_reg;

            r4_data_reg   <= r4_data_next;
        end
    end

    assign out_valid = r4_valid_reg;
    assign out_data  = r4_data_reg;

endmodule

`default_nettype wire

[hdl/cau_step.sv]
// One iteration stage: a quotient bit for both divisions, a root bit and
// one CORDIC rotation while IDX is below CORDIC_STEPS. Depends on cau_pkg.
`default_nettype none

module cau_step #(
    parameter int IDX = 0
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           adv,
    input  wire logic           in_valid,
    input  wire cau_pkg::step_t in_data,
    output logic                out_valid,
    output cau_pkg::step_t      out_data
);
    import cau_pkg::*;

    localparam int QK      = NSTEP - 1 - IDX;
    localparam int BIT_POS = 62 - 2 * IDX;
    localparam bit USE_ROT = IDX < CORDIC_STEPS;
    localparam int AI      = USE_ROT ? IDX : 0;

    logic               valid_reg;
    step_t              data_reg, data_next;
    logic [REM_W-1:0]   dsh_w;
    logic [63:0]        bit_w, trial_w;
    logic signed [33:0] x_w, y_w, z_w, ax_w;

    always_comb
    begin
        data_next = in_data;

        // Restoring division, one bit for each part
        dsh_w = REM_W'(in_data.den) << QK;
        if (in_data.rem_re >= dsh_w)
        begin
            data_next.rem_re   = in_data.rem_re - dsh_w;
            data_next.q_re[QK] = 1'b1;
        end
        if (in_data.rem_im >= dsh_w)
        begin
            data_next.rem_im   = in_data.rem_im - dsh_w;
            data_next.q_im[QK] = 1'b1;
        end

        // Integer square root, one bit
        bit_w   = 64'd1 << BIT_POS;
        trial_w = in_data.sq_res + bit_w;
        if (in_data.sq_n >= trial_w)
        begin
            data_next.sq_n   = in_data.sq_n - trial_w;
            data_next.sq_res = (in_data.sq_res >> 1) + bit_w;
        end
        else
        begin
            data_next.sq_res = in_data.sq_res >> 1;
        end

        // CORDIC vectoring rotation, only while IDX is below CORDIC_STEPS
        x_w  = $signed(in_data.cx);
        y_w  = $signed(in_data.cy);
        z_w  = $signed(in_data.cz);
        ax_w = $signed({2'b00, ATAN_Q30[AI]});
        if (USE_ROT)
        begin
            if (!y_w[33])
            begin
                data_next.cx = 34'(x_w + (y_w >>> IDX));
                data_next.cy = 34'(y_w - (x_w >>> IDX));
                data_next.cz = 34'(z_w + ax_w);
            end
            else
            begin
                data_next.cx = 34'(x_w - (y_w >>> IDX));
                data_next.cy = 34'(y_w + (x_w >>> IDX));
                data_next.cz = 34'(z_w - ax_w);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

[hdl/cau_back.sv]
// Result stage: final saturation, angle rounding, opcode select and the
// output register. Depends on cau_pkg.
`default_nettype none

module cau_back #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           adv,
    input  wire logic           in_valid,
    input  wire cau_pkg::step_t in_data,
    output logic                out_valid,
    output logic [31:0]         res_re,
    output logic [31:0]         res_im,
    output logic                is_equal,
    output logic [1:0]          status
);
    import cau_pkg::*;

    localparam int SH = 30 - FRAC_BITS;

    logic        valid_reg;
    logic [31:0] res_re_reg, res_im_reg, res_re_next, res_im_next;
    logic        eq_reg, eq_next;
    logic [1:0]  status_reg, status_next;
    logic [32:0] qre_w, qim_w, mod_w;
    logic [33:0] zc_w, rnd_w;

    always_comb
    begin
        qre_w = in_data.ovf_re ? {1'b1, in_data.neg_re ? INT_MIN : INT_MAX}
                               : sat_mag(in_data.neg_re, 65'(in_data.q_re));
        qim_w = in_data.ovf_im ? {1'b1, in_data.neg_im ? INT_MIN : INT_MAX}
                               : sat_mag(in_data.neg_im, 65'(in_data.q_im));
        mod_w = sat_mag(1'b0, 65'(in_data.sq_res));
        zc_w  = in_data.cz[33] ? '0 : in_data.cz;
        rnd_w = zc_w + (34'd1 << (SH - 1));

        res_re_next = in_data.res_re;
        res_im_next = in_data.res_im;
        status_next = in_data.status;
        eq_next     = in_data.is_eq;
        case (in_data.func)
            FN_DIV:
            begin
                if (in_data.divz)
                begin
                    res_re_next = '0;
                    res_im_next = '0;
                    status_next = ST_DIVZ;
                end
                else
                begin
                    res_re_next = qre_w[31:0];
                    res_im_next = qim_w[31:0];
                    status_next = (qre_w[32] || qim_w[32]) ? ST_SAT : ST_OK;
                end
            end
            FN_MOD:
            begin
                res_re_next = mod_w[31:0];
                res_im_next = '0;
                status_next = mod_w[32] ? ST_SAT : ST_OK;
            end
            FN_ANGLE:
            begin
                res_im_next = '0;
                if (in_data.zmod)
                begin
                    res_re_next = '0;
                    status_next = ST_ZMOD;
                end
                else
                begin
                    res_re_next = 32'(rnd_w >> SH);
                    status_next = ST_OK;
                end
            end
            default:
            begin
                res_re_next = in_data.res_re;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    // Hold the beat until it is taken
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_re_reg <= res_re_next;
            res_im_reg <= res_im_next;
            eq_reg     <= eq_next;
            status_reg <= status_next;
        end
    end

    assign out_valid = valid_reg;
    assign res_re    = res_re_reg;
    assign res_im    = res_im_reg;
    assign is_equal  = eq_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

[hdl/complex_arithmetic_unit.sv]
// Top level of the complex arithmetic unit: tolerance register, front stages,
// the iteration chain and the result stage. Depends on cau_pkg and submodules.
`default_nettype none

// Fixed-point complex ALU on signed Q16.16 operands (FRAC_BITS fraction bits).
// Every opcode runs through the same 38-stage pipeline: one input register,
// four stages of products, sums and setup, 32 iteration stages (a quotient bit
// for divide, a root bit for modulus and, below CORDIC_STEPS, a CORDIC rotation
// for angle) and the output register. One beat is taken every cycle unless the
// pipe holds; the 32-stage iteration chain sets the depth. When a result waits
// at the output, the whole pipe holds and in_ready drops. The tolerance register
// resets to one LSB and should be written only while the pipe is empty.

module complex_arithmetic_unit #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [31:0]        cfg_wdata,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [3:0]         func,
    input  wire logic signed [31:0] a_re,
    input  wire logic signed [31:0] a_im,
    input  wire logic signed [31:0] b_re,
    input  wire logic signed [31:0] b_im,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      res_re,
    output logic signed [31:0]      res_im,
    output logic                    is_equal,
    output logic [1:0]              status
);
    import cau_pkg::*;

    logic [31:0] tol_value_reg;
    logic        adv;
    logic        chain_valid [NSTEP+1];
    step_t       chain_data  [NSTEP+1];
    logic [31:0] res_re_w, res_im_w;

    // Advance the whole pipe unless a result is stuck at the output
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    // Equality tolerance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_value_reg <= 32'd1;
        else if (cfg_we)
            tol_value_reg <= cfg_wdata;
    end

    cau_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid),
        .func      (func),
        .a_re      (a_re),
        .a_im      (a_im),
        .b_re      (b_re),
        .b_im      (b_im),
        .tol       (tol_value_reg),
        .out_valid (chain_valid[0]),
        .out_data  (chain_data[0])
    );

    for (genvar g = 0; g < NSTEP; g++)
    begin : g_step
        cau_step #(
            .IDX (g)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (chain_valid[g]),
            .in_data   (chain_data[g]),
            .out_valid (chain_valid[g+1]),
            .out_data  (chain_data[g+1])
        );
    end

    cau_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (chain_valid[NSTEP]),
        .in_data   (chain_data[NSTEP]),
        .out_valid (out_valid),
        .res_re    (res_re_w),
        .res_im    (res_im_w),
        .is_equal  (is_equal),
        .status    (status)
    );

    assign res_re = $signed(res_re_w);
    assign res_im = $signed(res_im_w);

endmodule

`default_nettype wire
